// ===== design/ritoa_pkg.sv =====
// Shared types, constants and helpers for the radix integer-to-ASCII unit.
// No dependencies; all files but the checker refer to it by scoped names.

package ritoa_pkg;

  // Field widths fixed by the item format
  localparam int ValueW = 64;
  localparam int BaseW  = 6;
  localparam int CharW  = 7;
  localparam int DigitW = 6;

  // Radix limits and ASCII anchors
  localparam logic [BaseW-1:0] RADIX_MIN  = 6'd2;
  localparam logic [BaseW-1:0] RADIX_MAX  = 6'd36;
  localparam logic [DigitW-1:0] DEC_TOP   = 6'd9;
  localparam logic [CharW-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CharW-1:0] CHAR_ALPHA = 7'd65;
  localparam logic [CharW-1:0] ALPHA_BASE = 7'd10;

  // Commands from the sequencer to the divider
  typedef struct packed {
    logic load;  // take a new dividend and radix, start dividing
    logic next;  // divide the quotient just produced once more
  } ritoa_div_ctrl_t;

  // Status from the divider back to the sequencer
  typedef struct packed {
    logic              done;       // one-cycle pulse: a division finished
    logic [DigitW-1:0] digit;      // remainder of the finished division
    logic              quot_zero;  // quotient of the finished division is zero
  } ritoa_div_stat_t;

  // Map a digit value to its ASCII code
  function automatic logic [CharW-1:0] ascii_of(input logic [DigitW-1:0] d);
    if (d <= DEC_TOP) begin
      return CHAR_ZERO + {1'b0, d};
    end
    return CHAR_ALPHA + {1'b0, d} - ALPHA_BASE;
  endfunction

endpackage

// ===== design/ritoa_if.sv =====
// Valid/ready channel interfaces for the radix integer-to-ASCII unit.
// Depends on ritoa_pkg for the field widths.

interface ritoa_in_if;
  logic                          valid;
  logic                          ready;
  logic [ritoa_pkg::ValueW-1:0]  value;
  logic                          is_signed;
  logic [ritoa_pkg::BaseW-1:0]   base;

  modport source (output valid, value, is_signed, base, input ready);
  modport sink   (input valid, value, is_signed, base, output ready);
endinterface

interface ritoa_out_if;
  logic                          valid;
  logic                          ready;
  logic [ritoa_pkg::CharW-1:0]   char_code;
  logic                          negative;
  logic                          last;

  modport source (output valid, char_code, negative, last, input ready);
  modport sink   (input valid, char_code, negative, last, output ready);
endinterface

// ===== design/ritoa_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, keeps its quotient
// so it can be divided again for the next digit. Depends on ritoa_pkg.

module ritoa_divider #(
  parameter int VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ritoa_pkg::ritoa_div_ctrl_t    ctrl,
  input  logic [VALUE_BITS-1:0]         dividend,
  input  logic [ritoa_pkg::BaseW-1:0]   radix,
  output ritoa_pkg::ritoa_div_stat_t    stat
);

  localparam int CntW = $clog2(VALUE_BITS);
  localparam logic [CntW-1:0] CntTop = CntW'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0]          quot;
  logic [ritoa_pkg::DigitW-1:0]   rem;
  logic [ritoa_pkg::BaseW-1:0]    radix_q;
  logic [CntW-1:0]                cnt;
  logic                           busy;
  logic                           done;

  logic [ritoa_pkg::DigitW:0]     partial;
  logic [ritoa_pkg::DigitW:0]     diff;
  logic                           ge;

  // Shift in the next dividend bit and trial-subtract the radix
  always_comb begin
    partial = {rem, quot[VALUE_BITS-1]};
    diff    = partial - {1'b0, radix_q};
    ge      = partial >= {1'b0, radix_q};
  end

  // Control: busy flag, bit counter, finish pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (ctrl.load || ctrl.next) begin
        busy <= 1'b1;
        cnt  <= CntTop;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shift register and narrow remainder
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quot    <= dividend;
      radix_q <= radix;
      rem     <= '0;
    end else if (ctrl.next) begin
      rem <= '0;
    end else if (busy) begin
      quot <= {quot[VALUE_BITS-2:0], ge};
      rem  <= ge ? diff[ritoa_pkg::DigitW-1:0] : partial[ritoa_pkg::DigitW-1:0];
    end
  end

  assign stat.done      = done;
  assign stat.digit     = rem;
  assign stat.quot_zero = (quot == '0);

endmodule

// ===== design/ritoa_digit_buf.sv =====
// Digit store: one write port, one registered read port, ASCII mapping of
// the read digit. Depends on ritoa_pkg.

module ritoa_digit_buf #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [$clog2(MAX_DIGITS)-1:0]     wr_addr,
  input  logic [ritoa_pkg::DigitW-1:0]      wr_digit,
  input  logic                              rd_en,
  input  logic [$clog2(MAX_DIGITS)-1:0]     rd_addr,
  output logic [ritoa_pkg::CharW-1:0]       char_code
);

  logic [ritoa_pkg::DigitW-1:0] mem [MAX_DIGITS];
  logic [ritoa_pkg::DigitW-1:0] rd_data;

  // Store remainders as they come out of the divider
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_digit;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign char_code = ritoa_pkg::ascii_of(rd_data);

endmodule

// ===== design/radix_integer_to_ascii_unit.sv =====
// Radix integer-to-ASCII unit. Takes one item (value, is_signed, base) at a
// time and returns its digits as ASCII beats, most significant first, with
// negative on every beat and last on the final digit. Base saturates to 2..36.
// Each digit is one full pass of the bit-serial divider, and each emitted digit
// is a memory read, then an output beat. The next item is accepted once the
// last beat of the current one is taken. Depends on ritoa_pkg, ritoa_if,
// ritoa_divider and ritoa_digit_buf.

module radix_integer_to_ascii_unit #(
  parameter int MAX_DIGITS = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  ritoa_in_if.sink          req,
  ritoa_out_if.source       rsp
);

  localparam int AddrW = $clog2(MAX_DIGITS);
  localparam logic [AddrW-1:0] AddrTop = AddrW'(MAX_DIGITS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [AddrW-1:0] count;
  logic [AddrW-1:0] ptr;
  logic             neg;

  ritoa_pkg::ritoa_div_ctrl_t   div_ctrl;
  ritoa_pkg::ritoa_div_stat_t   div_stat;
  logic [VALUE_BITS-1:0]        raw;
  logic [VALUE_BITS-1:0]        magnitude;
  logic                         is_neg;
  logic [ritoa_pkg::BaseW-1:0]  radix;
  logic                         in_fire;
  logic                         out_fire;
  logic                         digit_done;
  logic                         conv_end;

  assign in_fire  = req.valid && req.ready;
  assign out_fire = rsp.valid && rsp.ready;

  // Take the magnitude and saturate the radix
  always_comb begin
    raw       = req.value[VALUE_BITS-1:0];
    is_neg    = req.is_signed && raw[VALUE_BITS-1];
    magnitude = is_neg ? (~raw + 1'b1) : raw;
    if (req.base < ritoa_pkg::RADIX_MIN) begin
      radix = ritoa_pkg::RADIX_MIN;
    end else if (req.base > ritoa_pkg::RADIX_MAX) begin
      radix = ritoa_pkg::RADIX_MAX;
    end else begin
      radix = req.base;
    end
  end

  // Sequence: divide until the quotient is zero or the store is full, then emit
  always_comb begin
    digit_done    = (state == S_DIV) && div_stat.done;
    conv_end      = div_stat.quot_zero || (count == AddrTop);
    div_ctrl.load = in_fire;
    div_ctrl.next = digit_done && !conv_end;
    state_next    = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_DIV;
      S_DIV:  if (digit_done && conv_end) state_next = S_RD;
      S_RD:   state_next = S_OUT;
      S_OUT: begin
        if (out_fire) begin
          state_next = (ptr == '0) ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ptr   <= '0;
      neg   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        count <= '0;
        neg   <= is_neg;
      end else if (digit_done) begin
        if (conv_end) begin
          ptr <= count;
        end else begin
          count <= count + 1'b1;
        end
      end else if (out_fire && (ptr != '0)) begin
        ptr <= ptr - 1'b1;
      end
    end
  end

  ritoa_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (magnitude),
    .radix    (radix),
    .stat     (div_stat)
  );

  ritoa_digit_buf #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_buf (
    .clk       (clk),
    .wr_en     (digit_done),
    .wr_addr   (count),
    .wr_digit  (div_stat.digit),
    .rd_en     (state == S_RD),
    .rd_addr   (ptr),
    .char_code (rsp.char_code)
  );

  // Handshake and beat flags
  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = (state == S_OUT);
  assign rsp.negative = neg;
  assign rsp.last     = (ptr == '0);

endmodule

// ===== design/ritoa_checker.sv =====
// Port-level checks for radix_integer_to_ascii_unit, attached by bind.
// Depends on the top level's channel ports only.

module ritoa_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // Hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // Never take a new item while a beat is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while output beat pending");

  // A beat needs at least one division after the accept
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("output beat right after accept");

  // Return to ready after the final beat
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("not ready after final beat");

endmodule

bind radix_integer_to_ascii_unit ritoa_checker u_ritoa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_last  (rsp.last)
);
